// File: rtl/core/dbrb_pkg.sv
// Shared types and constants for the DNS blocking-response builder.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package dbrb_pkg;

  // Channel payloads
  typedef struct packed {
    logic [7:0] request_byte;
    logic       start_of_packet;
  } in_item_t;

  typedef struct packed {
    logic [7:0] response_byte;
    logic       end_of_response;
  } out_item_t;

  // Classified item handed from the parser to the emitter
  typedef struct packed {
    logic       is_answer;   // last class byte: echo it, then append the answer
    logic [7:0] data;        // byte to echo (already patched for the header)
    logic [7:0] class_high;  // class high byte seen earlier in the question
  } entry_t;

  // Queue handshake between parser and emitter
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_head_t;

  // Parser phases, one-hot
  typedef enum logic [7:0] {
    PH_HEADER   = 8'b0000_0001,
    PH_LEN      = 8'b0000_0010,
    PH_LABEL    = 8'b0000_0100,
    PH_TYPE_HI  = 8'b0000_1000,
    PH_TYPE_LO  = 8'b0001_0000,
    PH_CLASS_HI = 8'b0010_0000,
    PH_CLASS_LO = 8'b0100_0000,
    PH_DONE     = 8'b1000_0000
  } phase_t;

  // Configuration register indexes
  localparam logic CFG_ANSWER_TTL     = 1'b0;
  localparam logic CFG_ANSWER_ADDRESS = 1'b1;

  localparam logic [31:0] TTL_RESET     = 32'd174;
  localparam logic [31:0] ADDRESS_RESET = 32'd0;

  // Header layout
  localparam logic [3:0] HDR_FLAGS_HI_POS  = 4'd2;
  localparam logic [3:0] HDR_FLAGS_LO_POS  = 4'd3;
  localparam logic [3:0] HDR_ANCOUNT_LO_POS = 4'd7;
  localparam logic [3:0] HDR_LAST_POS      = 4'd11;

  localparam logic [7:0] FLAGS_HI      = 8'h80;
  localparam logic [7:0] FLAGS_LO      = 8'h03;
  localparam logic [7:0] ANCOUNT_LO    = 8'h01;
  localparam logic [7:0] NAME_PTR_HI   = 8'hc0;
  localparam logic [7:0] NAME_PTR_LO   = 8'h0c;
  localparam logic [7:0] TYPE_A_LO     = 8'h01;
  localparam logic [7:0] RDLEN_LO      = 8'h04;
  localparam logic [7:0] ZERO_BYTE     = 8'h00;

  // Emitter byte index within an answer burst (0 = echoed class low byte)
  localparam int         ANSWER_IDX_W = 5;
  localparam logic [4:0] AIDX_ECHO    = 5'd0;
  localparam logic [4:0] AIDX_PTR_HI  = 5'd1;
  localparam logic [4:0] AIDX_PTR_LO  = 5'd2;
  localparam logic [4:0] AIDX_TYPE_HI = 5'd3;
  localparam logic [4:0] AIDX_TYPE_LO = 5'd4;
  localparam logic [4:0] AIDX_CLS_HI  = 5'd5;
  localparam logic [4:0] AIDX_CLS_LO  = 5'd6;
  localparam logic [4:0] AIDX_TTL3    = 5'd7;
  localparam logic [4:0] AIDX_TTL2    = 5'd8;
  localparam logic [4:0] AIDX_TTL1    = 5'd9;
  localparam logic [4:0] AIDX_TTL0    = 5'd10;
  localparam logic [4:0] AIDX_LEN_HI  = 5'd11;
  localparam logic [4:0] AIDX_LEN_LO  = 5'd12;
  localparam logic [4:0] AIDX_ADDR3   = 5'd13;
  localparam logic [4:0] AIDX_ADDR2   = 5'd14;
  localparam logic [4:0] AIDX_ADDR1   = 5'd15;
  localparam logic [4:0] AIDX_LAST    = 5'd16;

  // Default depth of the parser-to-emitter queue
  localparam int QUEUE_DEPTH = 4;

endpackage

`default_nettype wire

// File: rtl/core/dbrb_front.sv
// Request parser: accepts request bytes, tracks the header/question phase and
// pushes one classified entry per byte that produces output. Uses dbrb_pkg.
`default_nettype none

module dbrb_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire dbrb_pkg::in_item_t in_item,
  input  wire logic              q_full,
  output dbrb_pkg::q_push_t      push
);

  dbrb_pkg::phase_t phase_r, phase_nxt, phase_cur;
  logic [3:0] header_pos_r, header_pos_nxt, header_pos_cur;
  logic [7:0] label_rem_r, label_rem_nxt, label_rem_cur, label_dec;
  logic [7:0] class_high_r, class_high_nxt;
  logic       accept;
  logic [7:0] b;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign b        = in_item.request_byte;
  assign label_dec = label_rem_cur - 8'd1;

  // Classify the byte and work out the next parse state
  always_comb begin
    phase_cur      = phase_r;
    header_pos_cur = header_pos_r;
    label_rem_cur  = label_rem_r;
    if (in_item.start_of_packet) begin
      phase_cur      = dbrb_pkg::PH_HEADER;
      header_pos_cur = 4'd0;
      label_rem_cur  = 8'd0;
    end

    phase_nxt      = phase_cur;
    header_pos_nxt = header_pos_cur;
    label_rem_nxt  = label_rem_cur;
    class_high_nxt = class_high_r;

    push.valid            = 1'b0;
    push.entry.is_answer  = 1'b0;
    push.entry.data       = b;
    push.entry.class_high = class_high_r;

    unique case (phase_cur)
      dbrb_pkg::PH_HEADER: begin
        push.valid = accept;
        if (header_pos_cur == dbrb_pkg::HDR_FLAGS_HI_POS) begin
          push.entry.data = dbrb_pkg::FLAGS_HI;
        end else if (header_pos_cur == dbrb_pkg::HDR_FLAGS_LO_POS) begin
          push.entry.data = dbrb_pkg::FLAGS_LO;
        end else if (header_pos_cur == dbrb_pkg::HDR_ANCOUNT_LO_POS) begin
          push.entry.data = dbrb_pkg::ANCOUNT_LO;
        end
        if (header_pos_cur >= dbrb_pkg::HDR_LAST_POS) begin
          header_pos_nxt = 4'd0;
          phase_nxt      = dbrb_pkg::PH_LEN;
        end else begin
          header_pos_nxt = header_pos_cur + 4'd1;
        end
      end
      dbrb_pkg::PH_LEN: begin
        push.valid = accept;
        if (b == dbrb_pkg::ZERO_BYTE) begin
          phase_nxt = dbrb_pkg::PH_TYPE_HI;
        end else begin
          label_rem_nxt = b;
          phase_nxt     = dbrb_pkg::PH_LABEL;
        end
      end
      dbrb_pkg::PH_LABEL: begin
        push.valid    = accept;
        label_rem_nxt = label_dec;
        if (label_dec == 8'd0) begin
          phase_nxt = dbrb_pkg::PH_LEN;
        end
      end
      dbrb_pkg::PH_TYPE_HI: begin
        push.valid = accept;
        phase_nxt  = dbrb_pkg::PH_TYPE_LO;
      end
      dbrb_pkg::PH_TYPE_LO: begin
        push.valid = accept;
        phase_nxt  = dbrb_pkg::PH_CLASS_HI;
      end
      dbrb_pkg::PH_CLASS_HI: begin
        push.valid     = accept;
        class_high_nxt = b;
        phase_nxt      = dbrb_pkg::PH_CLASS_LO;
      end
      dbrb_pkg::PH_CLASS_LO: begin
        push.valid           = accept;
        push.entry.is_answer = 1'b1;
        phase_nxt            = dbrb_pkg::PH_DONE;
      end
      dbrb_pkg::PH_DONE: begin
        // drop trailing bytes
        push.valid = 1'b0;
      end
      default: begin
        push.valid = 1'b0;
        phase_nxt  = dbrb_pkg::PH_HEADER;
      end
    endcase
  end

  // Advance the parse state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= dbrb_pkg::PH_HEADER;
      header_pos_r <= 4'd0;
      label_rem_r  <= 8'd0;
      class_high_r <= 8'd0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      header_pos_r <= header_pos_nxt;
      label_rem_r  <= label_rem_nxt;
      class_high_r <= class_high_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/dbrb_queue.sv
// Small FIFO that decouples the parser from the emitter.
// Holds dbrb_pkg::entry_t items; depth is set by the DEPTH parameter.
`default_nettype none

module dbrb_queue #(
  parameter int DEPTH = dbrb_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dbrb_pkg::q_push_t push,
  output logic                   full,
  output dbrb_pkg::q_head_t      head,
  input  wire logic              pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  dbrb_pkg::entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == CNT_FULL);
  assign head.valid = (count_r != '0);
  assign head.entry = mem_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  // Advance pointers with wrap at the configured depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries; payload needs no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/dbrb_back.sv
// Response emitter: drains the queue into the output register, expanding an
// answer entry into a 17-byte burst. Uses dbrb_pkg and the configured TTL/address.
`default_nettype none

module dbrb_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dbrb_pkg::q_head_t  head,
  output logic                    pop,
  input  wire logic [31:0]        answer_ttl,
  input  wire logic [31:0]        answer_address,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output dbrb_pkg::out_item_t     out_item
);

  logic                              out_valid_r;
  dbrb_pkg::out_item_t               out_item_r, out_item_nxt;
  logic [dbrb_pkg::ANSWER_IDX_W-1:0] idx_r, idx_nxt;
  logic                              adv;
  logic                              last_of_entry;
  logic [7:0]                        ans_byte;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Output register is free when empty or being taken
  assign adv = !out_valid_r || !out_stall;
  assign last_of_entry = !head.entry.is_answer || (idx_r == dbrb_pkg::AIDX_LAST);
  assign pop = adv && head.valid && last_of_entry;

  // Select the answer byte at the current burst index
  always_comb begin
    unique case (idx_r)
      dbrb_pkg::AIDX_ECHO:    ans_byte = head.entry.data;
      dbrb_pkg::AIDX_PTR_HI:  ans_byte = dbrb_pkg::NAME_PTR_HI;
      dbrb_pkg::AIDX_PTR_LO:  ans_byte = dbrb_pkg::NAME_PTR_LO;
      dbrb_pkg::AIDX_TYPE_HI: ans_byte = dbrb_pkg::ZERO_BYTE;
      dbrb_pkg::AIDX_TYPE_LO: ans_byte = dbrb_pkg::TYPE_A_LO;
      dbrb_pkg::AIDX_CLS_HI:  ans_byte = head.entry.class_high;
      dbrb_pkg::AIDX_CLS_LO:  ans_byte = head.entry.data;
      dbrb_pkg::AIDX_TTL3:    ans_byte = answer_ttl[31:24];
      dbrb_pkg::AIDX_TTL2:    ans_byte = answer_ttl[23:16];
      dbrb_pkg::AIDX_TTL1:    ans_byte = answer_ttl[15:8];
      dbrb_pkg::AIDX_TTL0:    ans_byte = answer_ttl[7:0];
      dbrb_pkg::AIDX_LEN_HI:  ans_byte = dbrb_pkg::ZERO_BYTE;
      dbrb_pkg::AIDX_LEN_LO:  ans_byte = dbrb_pkg::RDLEN_LO;
      dbrb_pkg::AIDX_ADDR3:   ans_byte = answer_address[31:24];
      dbrb_pkg::AIDX_ADDR2:   ans_byte = answer_address[23:16];
      dbrb_pkg::AIDX_ADDR1:   ans_byte = answer_address[15:8];
      dbrb_pkg::AIDX_LAST:    ans_byte = answer_address[7:0];
      default:                ans_byte = dbrb_pkg::ZERO_BYTE;
    endcase
  end

  // Build the next output byte and burst index
  always_comb begin
    out_item_nxt.response_byte   = head.entry.is_answer ? ans_byte : head.entry.data;
    out_item_nxt.end_of_response = head.entry.is_answer && (idx_r == dbrb_pkg::AIDX_LAST);
    idx_nxt = idx_r;
    if (adv && head.valid && head.entry.is_answer) begin
      idx_nxt = (idx_r == dbrb_pkg::AIDX_LAST) ? dbrb_pkg::AIDX_ECHO
                                               : idx_r + dbrb_pkg::ANSWER_IDX_W'(1);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= dbrb_pkg::AIDX_ECHO;
    end else begin
      idx_r <= idx_nxt;
      if (adv) begin
        out_valid_r <= head.valid;
      end
    end
  end

  // Hold the payload while stalled
  always_ff @(posedge clk) begin
    if (adv && head.valid) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/dns_block_response_builder.sv
// DNS blocking-response builder, top level.
// Instantiates dbrb_front, dbrb_queue and dbrb_back; uses dbrb_pkg.
//
// Usage: request bytes enter on the in_ channel (valid/stall), one byte per
// item, with start_of_packet on the first header byte. Response bytes leave
// on the out_ channel, end_of_response set on the last byte of the answer.
// Header and question bytes each give one response byte; the last class byte
// gives 17 (its echo and the 16-byte answer). Bytes after the question give
// nothing.
// Timing: a response byte is registered in the queue and then in the output
// register before it appears on out_. Throughput: one request byte per cycle
// while the queue is not full; during an answer burst the parser runs ahead
// into the queue (QUEUE_DEPTH entries, four by default, the answer among them);
// the input stalls once the queue is full and resumes when the emitter pops.
// Stall: out_stall holds the output register; the queue keeps filling and
// in_stall rises once it is full.
// Configuration: cfg_index 0 writes the TTL, 1 the IPv4 address; write only
// while idle. Reset (synchronous, rst_n low) empties the queue, returns the
// parser to header byte 0 and loads TTL 174 and address 0. No clearing pass.
`default_nettype none

module dns_block_response_builder #(
  parameter int QUEUE_DEPTH = dbrb_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire dbrb_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output dbrb_pkg::out_item_t      out_item,
  input  wire logic                cfg_wr_en,
  input  wire logic                cfg_index,
  input  wire logic [31:0]         cfg_wr_data
);

  logic [31:0]       answer_ttl_r;
  logic [31:0]       answer_address_r;
  dbrb_pkg::q_push_t push;
  dbrb_pkg::q_head_t head;
  logic              q_full;
  logic              pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      answer_ttl_r     <= dbrb_pkg::TTL_RESET;
      answer_address_r <= dbrb_pkg::ADDRESS_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        dbrb_pkg::CFG_ANSWER_TTL:     answer_ttl_r     <= cfg_wr_data;
        dbrb_pkg::CFG_ANSWER_ADDRESS: answer_address_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  dbrb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .push     (push)
  );

  dbrb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .head  (head),
    .pop   (pop)
  );

  dbrb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .pop            (pop),
    .answer_ttl     (answer_ttl_r),
    .answer_address (answer_address_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item)
  );

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for dns_block_response_builder: drives request bytes,
// predicts every response byte and compares it field by field on the output.
// Depends on dbrb_pkg and the dns_block_response_builder RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 80;
  localparam int DRAIN_CYCLES   = 10;
  localparam int ITEMS_PER_STEP = 50;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  dbrb_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  dbrb_pkg::out_item_t out_item;
  logic                cfg_wr_en = 1'b0;
  logic                cfg_index = dbrb_pkg::CFG_ANSWER_TTL;
  logic [31:0]         cfg_wr_data = '0;

  // Stimulus and expectation stores
  dbrb_pkg::in_item_t  pending_bytes[$];
  dbrb_pkg::out_item_t expected_bytes[$];
  dbrb_pkg::out_item_t oldest_expected;
  int          fail_count = 0;
  int          queued_items = 0;
  int          idle_cycles = 0;

  // Idling knobs, percent of cycles
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        long_hold_req = 1'b0;
  logic        long_hold_started = 1'b0;
  int          long_hold_left = 0;

  // Predictor state
  dbrb_pkg::phase_t parse_phase = dbrb_pkg::PH_HEADER;
  logic [3:0]  hdr_pos = '0;
  logic [7:0]  label_left = '0;
  logic [7:0]  class_hi_seen = '0;
  logic [31:0] answer_ttl_q = dbrb_pkg::TTL_RESET;
  logic [31:0] answer_addr_q = dbrb_pkg::ADDRESS_RESET;

  dns_block_response_builder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void expect_byte(input logic [7:0] b, input logic last);
    dbrb_pkg::out_item_t e;
    e.response_byte   = b;
    e.end_of_response = last;
    expected_bytes = {expected_bytes, e};
  endfunction

  // Advance the parser by one request byte and queue the bytes it must send
  task automatic predict_response(input dbrb_pkg::in_item_t it);
    logic [7:0] b;
    b = it.request_byte;
    if (it.start_of_packet) begin
      parse_phase = dbrb_pkg::PH_HEADER;
      hdr_pos     = '0;
      label_left  = '0;
    end
    case (parse_phase)
      dbrb_pkg::PH_HEADER: begin
        if (hdr_pos == dbrb_pkg::HDR_FLAGS_HI_POS) expect_byte(dbrb_pkg::FLAGS_HI, 1'b0);
        else if (hdr_pos == dbrb_pkg::HDR_FLAGS_LO_POS) expect_byte(dbrb_pkg::FLAGS_LO, 1'b0);
        else if (hdr_pos == dbrb_pkg::HDR_ANCOUNT_LO_POS) begin
          expect_byte(dbrb_pkg::ANCOUNT_LO, 1'b0);
        end
        else expect_byte(b, 1'b0);
        if (hdr_pos >= dbrb_pkg::HDR_LAST_POS) begin
          hdr_pos     = '0;
          parse_phase = dbrb_pkg::PH_LEN;
        end else begin
          hdr_pos = hdr_pos + 4'd1;
        end
      end
      dbrb_pkg::PH_LEN: begin
        expect_byte(b, 1'b0);
        if (b == dbrb_pkg::ZERO_BYTE) begin
          parse_phase = dbrb_pkg::PH_TYPE_HI;
        end else begin
          label_left  = b;
          parse_phase = dbrb_pkg::PH_LABEL;
        end
      end
      dbrb_pkg::PH_LABEL: begin
        expect_byte(b, 1'b0);
        label_left = label_left - 8'd1;
        if (label_left == 8'd0) parse_phase = dbrb_pkg::PH_LEN;
      end
      dbrb_pkg::PH_TYPE_HI: begin
        expect_byte(b, 1'b0);
        parse_phase = dbrb_pkg::PH_TYPE_LO;
      end
      dbrb_pkg::PH_TYPE_LO: begin
        expect_byte(b, 1'b0);
        parse_phase = dbrb_pkg::PH_CLASS_HI;
      end
      dbrb_pkg::PH_CLASS_HI: begin
        expect_byte(b, 1'b0);
        class_hi_seen = b;
        parse_phase   = dbrb_pkg::PH_CLASS_LO;
      end
      dbrb_pkg::PH_CLASS_LO: begin
        // Echo the class low byte, then append the answer record
        expect_byte(b, 1'b0);
        expect_byte(dbrb_pkg::NAME_PTR_HI, 1'b0);
        expect_byte(dbrb_pkg::NAME_PTR_LO, 1'b0);
        expect_byte(dbrb_pkg::ZERO_BYTE, 1'b0);
        expect_byte(dbrb_pkg::TYPE_A_LO, 1'b0);
        expect_byte(class_hi_seen, 1'b0);
        expect_byte(b, 1'b0);
        expect_byte(answer_ttl_q[31:24], 1'b0);
        expect_byte(answer_ttl_q[23:16], 1'b0);
        expect_byte(answer_ttl_q[15:8], 1'b0);
        expect_byte(answer_ttl_q[7:0], 1'b0);
        expect_byte(dbrb_pkg::ZERO_BYTE, 1'b0);
        expect_byte(dbrb_pkg::RDLEN_LO, 1'b0);
        expect_byte(answer_addr_q[31:24], 1'b0);
        expect_byte(answer_addr_q[23:16], 1'b0);
        expect_byte(answer_addr_q[15:8], 1'b0);
        expect_byte(answer_addr_q[7:0], 1'b1);
        parse_phase = dbrb_pkg::PH_DONE;
      end
      default: begin
        // drop bytes after the question
      end
    endcase
  endtask

  // Driver: predict on acceptance, hold while stalled, else offer the next item
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) predict_response(in_item);
      if (!(in_valid && in_stall)) begin
        if (pending_bytes.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_item  <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: one long hold-off on request, random stalls otherwise
  always @(posedge clk) begin
    if (long_hold_req && !long_hold_started) begin
      long_hold_started <= 1'b1;
      long_hold_left    <= LONG_HOLD;
      out_stall         <= 1'b1;
    end else if (long_hold_left != 0) begin
      long_hold_left <= long_hold_left - 1;
      out_stall      <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  // Monitor: compare each accepted response byte with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected response item: response_byte %h end_of_response %b",
               out_item.response_byte, out_item.end_of_response);
        fail_count++;
      end else begin
        oldest_expected = expected_bytes.pop_front();
        if (out_item.response_byte !== oldest_expected.response_byte) begin
          $error("response_byte: expected %h, got %h",
                 oldest_expected.response_byte, out_item.response_byte);
          fail_count++;
        end
        if (out_item.end_of_response !== oldest_expected.end_of_response) begin
          $error("end_of_response: expected %b, got %b",
                 oldest_expected.end_of_response, out_item.end_of_response);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_byte(input logic [7:0] b, input logic sop);
    dbrb_pkg::in_item_t it;
    it.request_byte    = b;
    it.start_of_packet = sop;
    pending_bytes = {pending_bytes, it};
  endtask

  // Queue one request: random header and labels, sometimes cut short or restarted
  task automatic queue_request(input bit big_label);
    dbrb_pkg::in_item_t pkt[$];
    dbrb_pkg::in_item_t it;
    int       n_labels;
    int       len;
    int       cut;
    bit       truncated;
    truncated = 1'b0;
    for (int i = 0; i < 12; i++) begin
      it.request_byte    = 8'($urandom_range(255, 0));
      it.start_of_packet = (i == 0);
      pkt = {pkt, it};
    end
    n_labels = big_label ? $urandom_range(2, 1) : $urandom_range(3, 0);
    for (int l = 0; l < n_labels; l++) begin
      len = (big_label && l == 0) ? $urandom_range(255, 192) : $urandom_range(8, 1);
      it.request_byte    = 8'(len);
      it.start_of_packet = 1'b0;
      pkt = {pkt, it};
      for (int k = 0; k < len; k++) begin
        it.request_byte = 8'($urandom_range(255, 0));
        pkt = {pkt, it};
      end
    end
    it.request_byte = dbrb_pkg::ZERO_BYTE;
    pkt = {pkt, it};
    for (int k = 0; k < 4; k++) begin
      it.request_byte = 8'($urandom_range(255, 0));
      pkt = {pkt, it};
    end
    // Break some requests: restart mid-question or stop early
    if (!big_label && $urandom_range(9, 0) == 0)
      pkt[$urandom_range(pkt.size() - 1, 12)].start_of_packet = 1'b1;
    if (!big_label && $urandom_range(5, 0) == 0) begin
      cut       = $urandom_range(pkt.size() - 1, 1);
      pkt       = pkt[0:cut - 1];
      truncated = 1'b1;
    end
    queued_items += pkt.size();
    pending_bytes = {pending_bytes, pkt};
    // Trailing bytes after a complete question are dropped by the block
    if (!truncated) begin
      repeat ($urandom_range(2, 0)) add_byte(8'($urandom_range(255, 0)), 1'b0);
    end
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_valid || expected_bytes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [31:0] ttl, input logic [31:0] addr);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= dbrb_pkg::CFG_ANSWER_TTL;
    cfg_wr_data <= ttl;
    @(posedge clk);
    cfg_index   <= dbrb_pkg::CFG_ANSWER_ADDRESS;
    cfg_wr_data <= addr;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    answer_ttl_q  = ttl;
    answer_addr_q = addr;
  endtask

  initial begin
    logic [31:0] ttl_sel;
    logic [31:0] addr_sel;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Request without a start mark right after reset, root name, extreme bytes
    for (int i = 0; i < 12; i++) add_byte((i % 2 == 0) ? 8'hff : 8'h00, 1'b0);
    add_byte(dbrb_pkg::ZERO_BYTE, 1'b0);
    add_byte(8'hff, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hff, 1'b0);
    // Dropped byte after the question
    add_byte(8'h5a, 1'b0);
    // Request cut short inside the header; the next start mark abandons it
    add_byte(8'h12, 1'b1);
    for (int i = 1; i < 7; i++) add_byte(8'h80 >> i, 1'b0);
    wait_drained();

    // Four idling patterns, each under its own answer settings
    for (int step = 0; step < 4; step++) begin
      case (step)
        0: begin ttl_sel = 32'h0000_0000; addr_sel = 32'h0000_0000; end
        1: begin ttl_sel = 32'hffff_ffff; addr_sel = 32'hffff_ffff; end
        default: begin ttl_sel = $urandom; addr_sel = $urandom; end
      endcase
      write_config(ttl_sel, addr_sel);
      case (step)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      // Fill the block against a long receiver hold-off
      if (step == 0) long_hold_req = 1'b1;
      queued_items = 0;
      if (step == 2) queue_request(1'b1);
      while (queued_items < ITEMS_PER_STEP) queue_request(1'b0);
      wait_drained();
    end

    if (expected_bytes.size() != 0) begin
      $error("%0d response items never arrived", expected_bytes.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
